// ----- hdl/dra_pkg.sv -----
`timescale 1ns / 1ps
// Package for the DMA ring sampler: command codes, register indexes,
// beat and status types. No dependencies.
package dra_pkg;

  localparam int SAMPLE_W = 11;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 8;

  localparam logic [DATA_W-1:0] BAD_REG_VALUE = 32'h0bad_a4ea;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DIV    = 3'd0,
    REG_PAGE1  = 3'd1,
    REG_PAGE2  = 3'd2,
    REG_PAGE3  = 3'd3,
    REG_PAGE4  = 3'd4,
    REG_READP  = 3'd5,
    REG_WRITEP = 3'd6,
    REG_CTRL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    cmd_t              command;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                dma_valid;
    logic [DATA_W-1:0]   dma_address;
    logic [SAMPLE_W-1:0] dma_sample;
    logic                irq_line;
  } result_t;

  typedef struct packed {
    logic active;
    logic overrun;
    logic irq_latched;
    logic irq_level;
  } status_t;

endpackage

// ----- hdl/dra_core.sv -----
`timescale 1ns / 1ps
// Register map, ring pointers, sawtooth and interrupt state; computes one
// result per enabled beat. Depends on dra_pkg.
module dra_core import dra_pkg::*; #(
  parameter int RING_ADDR_BITS = 12,
  parameter int PAGE_ADDR_BITS = 10,
  parameter int BURST_LEN      = 100,
  parameter int SAW_PERIOD     = 1111
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  output result_t result,
  output status_t status
);

  localparam int BURST_W = $clog2(BURST_LEN + 1);
  localparam logic [BURST_W-1:0]  BURST_END = BURST_W'(BURST_LEN);
  localparam logic [SAMPLE_W:0]   SAW_END   = (SAMPLE_W + 1)'(SAW_PERIOD);
  localparam logic [DATA_W-1:0]   WORD_MASK = DATA_W'((64'd1 << PAGE_ADDR_BITS) - 64'd1);

  logic [DATA_W-1:0]         div_reg, div_reg_next;
  logic [DATA_W-1:0]         page [4];
  logic [DATA_W-1:0]         page_next [4];
  logic [DATA_W-1:0]         ctrl, ctrl_next;
  logic [RING_ADDR_BITS-1:0] rp, rp_next, wp, wp_next, wp_inc;
  logic                      overrun, overrun_next;
  logic                      irq_latched, irq_latched_next;
  logic                      irq_level, irq_level_next;
  logic                      active, active_next;
  logic [SAMPLE_W-1:0]       sample, sample_next;
  logic [SAMPLE_W:0]         sample_inc;
  logic [BURST_W-1:0]        burst, burst_next;
  logic [BURST_W:0]          burst_inc;
  logic [DATA_W-1:0]         wp_ext, word, base;
  logic [1:0]                page_sel;
  reg_idx_t                  ridx;

  assign wp_ext     = DATA_W'(wp);
  assign page_sel   = 2'((wp_ext >> PAGE_ADDR_BITS) & DATA_W'(3));
  assign word       = wp_ext & WORD_MASK;
  assign base       = page[page_sel];
  assign wp_inc     = wp + RING_ADDR_BITS'(1);
  assign sample_inc = {1'b0, sample} + (SAMPLE_W + 1)'(1);
  assign burst_inc  = {1'b0, burst} + (BURST_W + 1)'(1);
  assign ridx       = reg_idx_t'(item.reg_index[2:0]);

  always_comb begin
    div_reg_next     = div_reg;
    page_next        = page;
    ctrl_next        = ctrl;
    rp_next          = rp;
    wp_next          = wp;
    overrun_next     = overrun;
    irq_latched_next = irq_latched;
    irq_level_next   = irq_level;
    active_next      = active;
    sample_next      = sample;
    burst_next       = burst;
    result           = '0;
    unique case (item.command)
      CMD_READ: begin
        if (item.reg_index[IDX_W-1:3] != '0) begin
          result.read_data = BAD_REG_VALUE;
        end else begin
          unique case (ridx)
            REG_DIV:    result.read_data = div_reg;
            REG_PAGE1:  result.read_data = page[0];
            REG_PAGE2:  result.read_data = page[1];
            REG_PAGE3:  result.read_data = page[2];
            REG_PAGE4:  result.read_data = page[3];
            REG_READP:  result.read_data = {overrun, irq_latched,
                                            (DATA_W - 2 - RING_ADDR_BITS)'(0), rp};
            REG_WRITEP: result.read_data = wp_ext;
            REG_CTRL:   result.read_data = ctrl;
            default:    result.read_data = BAD_REG_VALUE;
          endcase
        end
      end
      CMD_WRITE: begin
        if (item.reg_index[IDX_W-1:3] == '0) begin
          unique case (ridx)
            REG_DIV: begin
              div_reg_next = item.write_data;
              active_next  = |item.write_data;
              rp_next      = '0;
              wp_next      = '0;
              overrun_next = 1'b0;
              burst_next   = '0;
            end
            REG_PAGE1: page_next[0] = item.write_data;
            REG_PAGE2: page_next[1] = item.write_data;
            REG_PAGE3: page_next[2] = item.write_data;
            REG_PAGE4: page_next[3] = item.write_data;
            REG_READP: rp_next = item.write_data[RING_ADDR_BITS-1:0];
            REG_WRITEP: ;
            REG_CTRL: begin
              ctrl_next      = item.write_data;
              irq_level_next = item.write_data[0] & irq_latched;
            end
            default: ;
          endcase
        end
      end
      CMD_SAMPLE: begin
        if (active) begin
          if (wp_inc == rp) begin
            overrun_next     = 1'b1;
            active_next      = 1'b0;
            burst_next       = '0;
            irq_latched_next = 1'b1;
            if (ctrl[0]) irq_level_next = 1'b1;
          end else if (!overrun) begin
            result.dma_valid   = 1'b1;
            result.dma_address = base + (word << 2);
            result.dma_sample  = sample;
            wp_next            = wp_inc;
            sample_next        = (sample_inc >= SAW_END) ? '0 : sample_inc[SAMPLE_W-1:0];
            if (burst_inc >= {1'b0, BURST_END}) begin
              burst_next       = '0;
              irq_latched_next = 1'b1;
              if (ctrl[0]) irq_level_next = 1'b1;
            end else begin
              burst_next = burst_inc[BURST_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    result.irq_line = irq_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_reg     <= '0;
      page        <= '{default: '0};
      ctrl        <= '0;
      rp          <= '0;
      wp          <= '0;
      overrun     <= 1'b0;
      irq_latched <= 1'b0;
      irq_level   <= 1'b0;
      active      <= 1'b0;
      sample      <= '0;
      burst       <= '0;
    end else if (en) begin
      div_reg     <= div_reg_next;
      page        <= page_next;
      ctrl        <= ctrl_next;
      rp          <= rp_next;
      wp          <= wp_next;
      overrun     <= overrun_next;
      irq_latched <= irq_latched_next;
      irq_level   <= irq_level_next;
      active      <= active_next;
      sample      <= sample_next;
      burst       <= burst_next;
    end
  end

  assign status = '{active: active, overrun: overrun,
                    irq_latched: irq_latched, irq_level: irq_level};

endmodule

// ----- hdl/dma_ring_adc_controller.sv -----
`timescale 1ns / 1ps
// Top level of the DMA ring sampler: input beat register, core, result
// register. Depends on dra_pkg and dra_core.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tuser command, s_tdata index + data
//  m_*     | out | m_tvalid/m_tready | m_tuser dma_valid, m_tdata results
//
// One beat per clock unless m_tready stalls (input register, then result register).
// State updates as a beat moves from the input register into the result
// register, so beats are handled strictly in order.
// A stalled m_tready holds the result; one more beat can wait in the input
// register before s_tready drops.
// Synchronous reset clears the register map, pointers and interrupt state.
module dma_ring_adc_controller import dra_pkg::*; #(
  parameter int RING_ADDR_BITS = 12,
  parameter int PAGE_ADDR_BITS = 10,
  parameter int BURST_LEN      = 100,
  parameter int SAW_PERIOD     = 1111
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // reg_index[7:0], write_data[39:8]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // read_data[31:0], dma_address[63:32],
                                 // dma_sample[74:64], irq_line[75], zero[79:76]
  output logic        m_tuser    // dma_valid
);

  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result, result_reg;
  status_t status;

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command    <= cmd_t'(s_tuser);
      item.reg_index  <= s_tdata[7:0];
      item.write_data <= s_tdata[39:8];
    end
  end

  dra_core #(
    .RING_ADDR_BITS(RING_ADDR_BITS),
    .PAGE_ADDR_BITS(PAGE_ADDR_BITS),
    .BURST_LEN     (BURST_LEN),
    .SAW_PERIOD    (SAW_PERIOD)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .item  (item),
    .result(result),
    .status(status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign m_tdata = {4'b0, result_reg.irq_line, result_reg.dma_sample,
                    result_reg.dma_address, result_reg.read_data};
  assign m_tuser = result_reg.dma_valid;

  a_no_active_overrun: assert property (@(posedge clk) disable iff (rst)
    !(status.active && status.overrun))
    else $error("sampling active while overrun is set");

  a_irq_needs_pending: assert property (@(posedge clk) disable iff (rst)
    status.irq_level |-> status.irq_latched)
    else $error("interrupt line high with nothing pending");

  a_dma_no_read_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[31:0] == '0))
    else $error("sample beat carries read data");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result lost after core step");

endmodule
